FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion shorthands for the matrix multiply engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define MME_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define MME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: rtl/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, widths and codes of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int ADDR_W     = 2 * DIM_W;
  localparam int MEM_DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ELEM_W     = 16;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int ACC_W      = 35;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int FUNC_W     = 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = CFG_W'(MAX_DIM);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2
  } func_t;

  typedef struct packed {
    func_t                     op;
    logic [DIM_W-1:0]          row;
    logic [DIM_W-1:0]          col;
    logic signed [ELEM_W-1:0]  value;
  } cmd_t;

  // last valid index of each dimension, already clamped
  typedef struct packed {
    logic [DIM_W-1:0] rows_last;
    logic [DIM_W-1:0] inner_last;
    logic [DIM_W-1:0] cols_last;
  } dims_t;

  // zero counts as one, anything above MAX_DIM as MAX_DIM
  function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > CFG_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM - 1);
    end else begin
      r = DIM_W'(v - CFG_W'(1));
    end
    return r;
  endfunction

endpackage

FILE: rtl/mme_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mme_cmd_fifo
// Short command queue between the front end and the compute back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mme_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mme_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output mme_pkg::cmd_t pop_cmd,
  output logic          not_empty
);

  mme_pkg::cmd_t                       entries_r [mme_pkg::FIFO_DEPTH];
  logic [mme_pkg::FIFO_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [mme_pkg::FIFO_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [mme_pkg::FIFO_CNT_W-1:0]      count_r, count_nxt;

  assign full      = (count_r == mme_pkg::FIFO_CNT_W'(mme_pkg::FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + mme_pkg::FIFO_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + mme_pkg::FIFO_PTR_W'(1) : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + mme_pkg::FIFO_CNT_W'(1);
      2'b01:   count_nxt = count_r - mme_pkg::FIFO_CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  `MME_ASSERT(a_fifo_no_overflow, clk, rst_n, push |-> !full, "push into full queue")
  `MME_ASSERT(a_fifo_no_underflow, clk, rst_n, pop |-> not_empty, "pop from empty queue")
  `MME_ASSERT(a_fifo_count_bound, clk, rst_n,
    count_r <= mme_pkg::FIFO_CNT_W'(mme_pkg::FIFO_DEPTH), "queue count out of range")

endmodule

FILE: rtl/mme_front.sv
// ----------------------------------------------------------------------------
// mme_front
// Takes input words, drops unused codes, queues commands; holds the sizes.
// ----------------------------------------------------------------------------
module mme_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mme_pkg::FUNC_W-1:0]          in_func,
  input  logic [mme_pkg::DIM_W-1:0]           in_row_index,
  input  logic [mme_pkg::DIM_W-1:0]           in_col_index,
  input  logic signed [mme_pkg::ELEM_W-1:0]   in_element_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mme_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mme_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                fifo_full,
  output logic                                push,
  output mme_pkg::cmd_t                       push_cmd,
  output mme_pkg::dims_t                      dims
);

  logic [mme_pkg::CFG_W-1:0] rows_a_r, rows_a_nxt;
  logic [mme_pkg::CFG_W-1:0] inner_size_r, inner_size_nxt;
  logic [mme_pkg::CFG_W-1:0] cols_b_r, cols_b_nxt;
  logic                      cfg_we;
  logic                      is_cmd;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_stall  = fifo_full;

  // func 3 carries no work: accept and drop
  assign is_cmd = (in_func == mme_pkg::FUNC_LOAD_A) || (in_func == mme_pkg::FUNC_LOAD_B) ||
                  (in_func == mme_pkg::FUNC_COMPUTE);
  assign push   = in_valid && !in_stall && is_cmd;

  always_comb begin
    push_cmd.op    = mme_pkg::func_t'(in_func);
    push_cmd.row   = in_row_index;
    push_cmd.col   = in_col_index;
    push_cmd.value = in_element_value;
  end

  always_comb begin
    rows_a_nxt     = rows_a_r;
    inner_size_nxt = inner_size_r;
    cols_b_nxt     = cols_b_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mme_pkg::CFG_ROWS_A:     rows_a_nxt     = cfg_data;
        mme_pkg::CFG_INNER_SIZE: inner_size_nxt = cfg_data;
        mme_pkg::CFG_COLS_B:     cols_b_nxt     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r     <= mme_pkg::CFG_DIM_RESET;
      inner_size_r <= mme_pkg::CFG_DIM_RESET;
      cols_b_r     <= mme_pkg::CFG_DIM_RESET;
    end else begin
      rows_a_r     <= rows_a_nxt;
      inner_size_r <= inner_size_nxt;
      cols_b_r     <= cols_b_nxt;
    end
  end

  assign dims.rows_last  = mme_pkg::dim_last(rows_a_r);
  assign dims.inner_last = mme_pkg::dim_last(inner_size_r);
  assign dims.cols_last  = mme_pkg::dim_last(cols_b_r);

endmodule

FILE: rtl/mme_back.sv
// ----------------------------------------------------------------------------
// mme_back
// Element stores and the multiply-accumulate sequencer that emits C.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mme_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cmd_valid,
  input  mme_pkg::cmd_t                      cmd,
  output logic                               cmd_pop,
  input  mme_pkg::dims_t                     dims,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mme_pkg::ACC_W-1:0]   out_product_value,
  output logic [mme_pkg::DIM_W-1:0]          out_row,
  output logic [mme_pkg::DIM_W-1:0]          out_col,
  output logic                               out_last_result
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [mme_pkg::ELEM_W-1:0] mem_a [mme_pkg::MEM_DEPTH];
  logic signed [mme_pkg::ELEM_W-1:0] mem_b [mme_pkg::MEM_DEPTH];

  logic [mme_pkg::DIM_W-1:0] i_r, i_nxt;
  logic [mme_pkg::DIM_W-1:0] j_r, j_nxt;
  logic [mme_pkg::DIM_W-1:0] k_r, k_nxt;

  logic                              wr_a, wr_b, load_out, issue;
  logic [mme_pkg::ADDR_W-1:0]        wr_addr;

  logic signed [mme_pkg::ELEM_W-1:0] rd_a_r, rd_b_r;
  logic                              rd_v_r, rd_first_r, rd_last_r;
  logic signed [mme_pkg::PROD_W-1:0] prod_r;
  logic                              prod_v_r, prod_first_r, prod_last_r;
  logic signed [mme_pkg::ACC_W-1:0]  acc_r, acc_sum;

  logic                              out_valid_r, out_valid_nxt;
  logic signed [mme_pkg::ACC_W-1:0]  out_value_r;
  logic [mme_pkg::DIM_W-1:0]         out_row_r, out_col_r;
  logic                              out_last_r;

  assign wr_addr = {cmd.row, cmd.col};
  assign issue   = (state_r == ST_ISSUE);

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    cmd_pop       = 1'b0;
    wr_a          = 1'b0;
    wr_b          = 1'b0;
    load_out      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            mme_pkg::FUNC_LOAD_A: wr_a = 1'b1;
            mme_pkg::FUNC_LOAD_B: wr_b = 1'b1;
            mme_pkg::FUNC_COMPUTE: begin
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
              state_nxt = ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        if (k_r == dims.inner_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + mme_pkg::DIM_W'(1);
        end
      end
      ST_DRAIN: begin
        // wait for the last product of this dot product to land
        if (prod_v_r && prod_last_r) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = '0;
            state_nxt = ST_ISSUE;
            if (j_r == dims.cols_last) begin
              j_nxt = '0;
              i_nxt = i_r + mme_pkg::DIM_W'(1);
            end else begin
              j_nxt = j_r + mme_pkg::DIM_W'(1);
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // restart the sum on the first product of each element
  always_comb begin
    if (prod_first_r) begin
      acc_sum = mme_pkg::ACC_W'(prod_r);
    end else begin
      acc_sum = acc_r + mme_pkg::ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= issue;
      prod_v_r    <= rd_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    rd_first_r   <= (k_r == '0);
    rd_last_r    <= (k_r == dims.inner_last);
    prod_r       <= rd_a_r * rd_b_r;
    prod_first_r <= rd_first_r;
    prod_last_r  <= rd_last_r;
    if (prod_v_r) begin
      acc_r <= acc_sum;
    end
    if (load_out) begin
      out_value_r <= acc_sum;
      out_row_r   <= i_r;
      out_col_r   <= j_r;
      out_last_r  <= (i_r == dims.rows_last) && (j_r == dims.cols_last);
    end
  end

  // element stores: one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= cmd.value;
    end
    rd_a_r <= mem_a[{i_r, k_r}];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[wr_addr] <= cmd.value;
    end
    rd_b_r <= mem_b[{k_r, j_r}];
  end

  assign out_valid         = out_valid_r;
  assign out_product_value = out_value_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_last_result   = out_last_r;

  `MME_ASSERT(a_back_emit_state, clk, rst_n, out_valid_r |-> (state_r == ST_EMIT), "result outside emit")
  `MME_ASSERT(a_back_pop_idle, clk, rst_n, cmd_pop |-> (state_r == ST_IDLE), "command taken while busy")
  `MME_ASSERT(a_back_drain_last, clk, rst_n, (prod_v_r && prod_last_r) |-> (state_r == ST_DRAIN),
    "final product outside drain")
  `MME_ASSERT(a_back_no_issue_gap, clk, rst_n, (issue && (k_r != dims.inner_last)) |=> issue,
    "issue stopped early")

endmodule

FILE: rtl/matrix_multiply_engine.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Dense C = A x B on signed Q8.8 elements with exact Q19.16 results.
// ----------------------------------------------------------------------------
// A front end takes one word per cycle into a four-entry command queue while
// that queue has room; a load word is written into its element store at the
// edge that takes it out of the queue. A compute word runs the back end for
// rows_a x cols_b result elements, emitted row-major with the final one
// flagged. Each element streams its inner_size products through one 16x16
// multiplier in a read / multiply / accumulate pipeline, and out_stall holds
// each result at the output until it is taken. The back end holds off
// further queued words until the last result is taken. Sizes of 0 act as 1,
// sizes above 8 as 8; write sizes only while the engine is idle, and load
// every element a product reads before issuing it.
// ----------------------------------------------------------------------------
module matrix_multiply_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mme_pkg::FUNC_W-1:0]         in_func,
  input  logic [mme_pkg::DIM_W-1:0]          in_row_index,
  input  logic [mme_pkg::DIM_W-1:0]          in_col_index,
  input  logic signed [mme_pkg::ELEM_W-1:0]  in_element_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mme_pkg::ACC_W-1:0]   out_product_value,
  output logic [mme_pkg::DIM_W-1:0]          out_row,
  output logic [mme_pkg::DIM_W-1:0]          out_col,
  output logic                               out_last_result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mme_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mme_pkg::CFG_W-1:0]          cfg_data
);

  logic           push, fifo_full, pop, not_empty;
  mme_pkg::cmd_t  push_cmd, pop_cmd;
  mme_pkg::dims_t dims;

  mme_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fifo_full        (fifo_full),
    .push             (push),
    .push_cmd         (push_cmd),
    .dims             (dims)
  );

  mme_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (fifo_full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .not_empty (not_empty)
  );

  mme_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (not_empty),
    .cmd               (pop_cmd),
    .cmd_pop           (pop),
    .dims              (dims),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_product_value (out_product_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_result   (out_last_result)
  );

endmodule
